// ===== design/a85_pkg.sv =====
package a85_pkg;

    // Character codes and encoder constants
    localparam logic [7:0] A85_OFFSET     = 8'h21;
    localparam logic [7:0] A85_ZERO_CHAR  = 8'h7A;
    localparam logic [7:0] A85_NEWLINE    = 8'h0A;
    localparam logic [7:0] A85_LINE_RESET = 8'd10;
    localparam logic [6:0] A85_BASE       = 7'd85;
    localparam logic [2:0] A85_FULL_DIGITS = 3'd5;

    // Reciprocal of 85 scaled by 2^38; exact quotient for any 32-bit dividend
    localparam logic [31:0] A85_RECIP       = 32'hC0C0C0C1;
    localparam int          A85_RECIP_SHIFT = 38;
    localparam int          A85_QUO_W       = 64 - A85_RECIP_SHIFT;

    // Input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
    } a85_in_t;

    // Output word
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       msg_end;
    } a85_out_t;

    // One group to encode, front to converter
    typedef struct packed {
        logic [31:0] val;
        logic [2:0]  ndig;
        logic        zero;
        logic        last;
    } a85_job_t;

    // Converted group, converter to emitter; dig[0] is most significant
    typedef struct packed {
        logic [4:0][6:0] dig;
        logic [2:0]      ndig;
        logic            zero;
        logic            last;
    } a85_res_t;

endpackage

// ===== design/ascii85_stream_encoder.sv =====
// Channel  Dir  Handshake          Word
// in       in   in_valid/in_stall  in_data   (in_byte, msg_last)
// out      out  out_valid/out_stall out_data (out_char, run_last, msg_end)
// cfg      in   cfg_valid/cfg_ready cfg_data (line_length)
//
// A nonzero four-byte group passes through the base-85 converter as four
// divide-by-85 steps, each a multiply state and a remainder state, plus hand-off;
// an all-zero group goes straight to hand-off.
// Characters leave at most one per cycle.
// Reset clears group, queue and line state and sets line_length to 10.
// out_stall holds the output register; backlog fills the group queue,
// then in_stall rises.
module ascii85_stream_encoder
    import a85_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  a85_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output a85_out_t   out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic     push;
    a85_job_t push_job;
    logic     q_full;
    logic     pop;
    logic     q_valid;
    a85_job_t q_job;
    logic     res_valid;
    a85_res_t res;
    logic     res_take;

    assign cfg_ready = 1'b1;

    a85_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    a85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    a85_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    a85_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== design/a85_front.sv =====
module a85_front
    import a85_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  a85_in_t  in_data,
    input  logic     q_full,
    output logic     push,
    output a85_job_t job
);

    logic [23:0] group_reg;
    logic [23:0] group_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        accept;
    logic [23:0] shifted;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign shifted  = {group_reg[15:0], in_data.in_byte};

    // Gather bytes and classify: full group, final partial group, or hold
    always_comb
    begin
        group_next = group_reg;
        fill_next  = fill_reg;
        push       = 1'b0;
        job        = '0;
        if (accept)
        begin
            if (fill_reg == 2'd3)
            begin
                push       = 1'b1;
                job.val    = {group_reg, in_data.in_byte};
                job.ndig   = A85_FULL_DIGITS;
                job.zero   = ({group_reg, in_data.in_byte} == 32'd0);
                job.last   = in_data.msg_last;
                group_next = '0;
                fill_next  = '0;
            end
            else if (in_data.msg_last)
            begin
                push      = 1'b1;
                job.zero  = 1'b0;
                job.last  = 1'b1;
                job.ndig  = {1'b0, fill_reg} + 3'd2;
                case (fill_reg)
                    2'd0:    job.val = {shifted[7:0], 24'd0};
                    2'd1:    job.val = {shifted[15:0], 16'd0};
                    default: job.val = {shifted, 8'd0};
                endcase
                group_next = '0;
                fill_next  = '0;
            end
            else
            begin
                group_next = shifted;
                fill_next  = fill_reg + 2'd1;
            end
        end
    end

    // Hold group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            group_reg <= group_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// ===== design/a85_queue.sv =====
module a85_queue
    import a85_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  a85_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     q_valid,
    output a85_job_t q_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    a85_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_job   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");
`endif

endmodule

// ===== design/a85_conv.sv =====
module a85_conv
    import a85_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  a85_job_t q_job,
    output logic     pop,
    output logic     res_valid,
    output a85_res_t res,
    input  logic     res_take
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_MUL  = 4'b0010,
        C_SUB  = 4'b0100,
        C_FIN  = 4'b1000
    } conv_state_t;

    conv_state_t           state_reg;
    conv_state_t           state_next;
    logic [31:0]           x_reg;
    logic [31:0]           x_next;
    logic [A85_QUO_W-1:0]  quo_reg;
    logic [A85_QUO_W-1:0]  quo_next;
    logic [1:0]            k_reg;
    logic [1:0]            k_next;
    logic [4:0][6:0]       dig_reg;
    logic [4:0][6:0]       dig_next;
    logic [2:0]            ndig_reg;
    logic [2:0]            ndig_next;
    logic                  zero_reg;
    logic                  zero_next;
    logic                  last_reg;
    logic                  last_next;
    a85_res_t              res_reg;
    a85_res_t              res_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic [63:0]           mul_full;
    logic [31:0]           quo85;
    logic [31:0]           rem32;
    logic [2:0]            dig_idx;
    logic                  slot_free;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign slot_free = !res_valid_reg || res_take;

    // Quotient by 85 through the scaled reciprocal, remainder on the next cycle
    assign mul_full = 64'(x_reg) * 64'(A85_RECIP);
    assign quo85    = 32'(quo_reg) * 32'(A85_BASE);
    assign rem32    = x_reg - quo85;
    assign dig_idx  = 3'd4 - {1'b0, k_reg};

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        quo_next       = quo_reg;
        k_next         = k_reg;
        dig_next       = dig_reg;
        ndig_next      = ndig_reg;
        zero_next      = zero_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        res_valid_next = res_take ? 1'b0 : res_valid_reg;
        pop            = 1'b0;

        unique case (state_reg)
            C_IDLE:
            begin
                pop = q_valid;
            end
            C_MUL:
            begin
                quo_next   = mul_full[63:A85_RECIP_SHIFT];
                state_next = C_SUB;
            end
            C_SUB:
            begin
                dig_next[dig_idx] = rem32[6:0];
                x_next            = 32'(quo_reg);
                k_next            = k_reg + 2'd1;
                state_next        = (k_reg == 2'd3) ? C_FIN : C_MUL;
            end
            C_FIN:
            begin
                if (slot_free)
                begin
                    res_next.dig    = {dig_reg[4:1], x_reg[6:0]};
                    res_next.ndig   = ndig_reg;
                    res_next.zero   = zero_reg;
                    res_next.last   = last_reg;
                    res_valid_next  = 1'b1;
                    pop             = q_valid;
                    state_next      = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase

        // Load the next group; an all-zero group needs no digits
        if (pop)
        begin
            x_next     = q_job.val;
            ndig_next  = q_job.ndig;
            zero_next  = q_job.zero;
            last_next  = q_job.last;
            k_next     = '0;
            state_next = q_job.zero ? C_FIN : C_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            res_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            k_reg         <= k_next;
        end
    end

    // Working and result data
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        quo_reg  <= quo_next;
        dig_reg  <= dig_next;
        ndig_reg <= ndig_next;
        zero_reg <= zero_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_sub_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_SUB) |-> ($past(state_reg) == C_MUL))
        else $error("remainder step without a quotient");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.zero) |->
        (res_reg.dig[0] < A85_BASE && res_reg.dig[4] < A85_BASE))
        else $error("base-85 digit out of range");
`endif

endmodule

// ===== design/a85_emit.sv =====
module a85_emit
    import a85_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic [7:0] cfg_data,
    input  logic     res_valid,
    input  a85_res_t res,
    output logic     res_take,
    output logic     out_valid,
    input  logic     out_stall,
    output a85_out_t out_data
);

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_CHAR = 4'b0010,
        E_NL   = 4'b0100,
        E_TAIL = 4'b1000
    } emit_state_t;

    emit_state_t state_reg;
    emit_state_t state_next;
    a85_res_t    job_reg;
    a85_res_t    job_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic [7:0]  col_reg;
    logic [7:0]  col_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    a85_out_t    out_data_reg;
    a85_out_t    out_data_next;
    logic        adv;
    logic [7:0]  col_inc;
    logic        wrap_on;
    logic        wrap;
    logic        more;
    logic        tail;
    logic [7:0]  cur_char;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign res_take  = (state_reg == E_IDLE) && res_valid;
    assign adv       = !out_valid_reg || !out_stall;

    // Line bookkeeping for the character at hand
    assign col_inc  = col_reg + 8'd1;
    assign wrap_on  = (len_reg != 8'd0);
    assign wrap     = wrap_on && (col_inc >= len_reg);
    assign more     = ((idx_reg + 3'd1) < job_reg.ndig) && !job_reg.zero;
    assign tail     = job_reg.last && wrap_on && (col_inc != 8'd0);
    assign cur_char = job_reg.zero ? A85_ZERO_CHAR
                                   : ({1'b0, job_reg.dig[idx_reg]} + A85_OFFSET);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        len_next       = cfg_we ? cfg_data : len_reg;
        out_valid_next = adv ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            E_IDLE:
            begin
                if (res_valid)
                begin
                    job_next   = res;
                    idx_next   = '0;
                    state_next = E_CHAR;
                end
            end
            E_CHAR:
            begin
                if (adv)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_char = cur_char;
                    out_data_next.run_last = 1'b0;
                    out_data_next.msg_end  = 1'b0;
                    if (wrap)
                    begin
                        col_next   = '0;
                        state_next = E_NL;
                    end
                    else
                    begin
                        if (wrap_on)
                        begin
                            col_next = col_inc;
                        end
                        if (more)
                        begin
                            idx_next = idx_reg + 3'd1;
                        end
                        else if (tail)
                        begin
                            state_next = E_TAIL;
                        end
                        else
                        begin
                            out_data_next.run_last = 1'b1;
                            out_data_next.msg_end  = job_reg.last;
                            state_next             = E_IDLE;
                            if (job_reg.last)
                            begin
                                col_next = '0;
                            end
                        end
                    end
                end
            end
            E_NL:
            begin
                if (adv)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_char = A85_NEWLINE;
                    out_data_next.run_last = !more;
                    out_data_next.msg_end  = !more && job_reg.last;
                    if (more)
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = E_CHAR;
                    end
                    else
                    begin
                        state_next = E_IDLE;
                    end
                end
            end
            E_TAIL:
            begin
                if (adv)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_char = A85_NEWLINE;
                    out_data_next.run_last = 1'b1;
                    out_data_next.msg_end  = 1'b1;
                    col_next               = '0;
                    state_next             = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            idx_reg       <= '0;
            col_reg       <= '0;
            len_reg       <= A85_LINE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold group and output word
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.msg_end) |-> out_data_reg.run_last)
        else $error("message end not on a run's last word");

    a_tail_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_TAIL) |-> (job_reg.last && len_reg != 8'd0))
        else $error("closing newline outside message end");
`endif

endmodule
